### rtl/core/heat_diffusion_stencil_5pt_macros.svh
// assertion macros used by the heat diffusion stencil top module
`ifndef HEAT_DIFFUSION_STENCIL_5PT_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_5PT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define HDS5_CHECK(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("hds5 invariant violated");

// antecedent in one cycle implies consequent in the same cycle
`define HDS5_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hds5 implication violated");

`endif

### rtl/core/hds5_pkg.sv
// shared types and constants for the heat diffusion stencil
package hds5_pkg;

	// default line buffer depth, largest grid side
	localparam int GRID_MAX_DEF = 1024;

	// field and register widths
	localparam int DATA_W     = 32;
	localparam int SIZE_W     = 11;
	localparam int GAIN_W     = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// laplacian and product widths
	localparam int LAP_W  = DATA_W + 4;
	localparam int PROD_W = LAP_W + GAIN_W + 1;
	localparam int FRAC_W = 16;

	// smallest grid side
	localparam int SIZE_MIN = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_GAIN   = 2'd2;

	// register reset values
	localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = 11'd1024;
	localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = 11'd1024;
	localparam logic [GAIN_W-1:0] DIFF_GAIN_RST   = 15'd13107;

	// output queue depth, bounds results in flight
	localparam int OUT_DEPTH = 8;

	// position flags of one accepted transaction
	typedef struct packed {
		logic emit;
		logic last;
	} scan_ctl_t;

	// control of one pipeline stage
	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

	// one result transaction
	typedef struct packed {
		logic              last;
		logic [DATA_W-1:0] value;
	} result_t;

endpackage

### rtl/core/heat_diffusion_stencil_5pt.sv
// One explicit heat-diffusion step with a 5-point stencil over a row-major cell
// stream. One cell is taken per clock while in_ready is high; each interior
// cell's new value passes the window, laplacian and product registers after the
// cell below and right of it is taken; boundary cells give no result. Throughput
// is set by the single read port of each of the two line buffers, read once per
// cell. After reset the line buffers are zeroed by a sweep over all GRID_MAX
// entries (1024 by default) while in_ready is low. At most OUT_DEPTH results may
// be outstanding; in_ready drops when the output side backs up that far.
`include "heat_diffusion_stencil_5pt_macros.svh"

module heat_diffusion_stencil_5pt #(
	parameter int GRID_MAX = hds5_pkg::GRID_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [hds5_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [hds5_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// cell stream
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [hds5_pkg::DATA_W-1:0]   cell_value,
	input  logic                                 frame_start,
	// result stream
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [hds5_pkg::DATA_W-1:0]   updated_value,
	output logic                                 pass_done
);

	localparam int AW   = $clog2(GRID_MAX);
	localparam int OD   = hds5_pkg::OUT_DEPTH;
	localparam int CNTW = $clog2(OD + 1);

	logic [hds5_pkg::SIZE_W-1:0] grid_width_q;
	logic [hds5_pkg::SIZE_W-1:0] grid_height_q;
	logic [hds5_pkg::GAIN_W-1:0] diff_gain_q;

	logic                        in_fire;
	logic                        out_fire;
	logic [AW-1:0]               scan_addr;
	hds5_pkg::scan_ctl_t         scan_ctl;
	logic                        clr_busy;
	hds5_pkg::stage_ctl_t        ctl_s2;
	logic signed [hds5_pkg::LAP_W-1:0]  lap_s2;
	logic signed [hds5_pkg::DATA_W-1:0] center_s2;
	logic                        res_valid;
	hds5_pkg::result_t           res;
	hds5_pkg::result_t           out_res;
	logic [CNTW-1:0]             out_level;
	logic [CNTW-1:0]             pend_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hds5_pkg::GRID_WIDTH_RST;
			grid_height_q <= hds5_pkg::GRID_HEIGHT_RST;
			diff_gain_q   <= hds5_pkg::DIFF_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				hds5_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata[hds5_pkg::SIZE_W-1:0];
				hds5_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_wdata[hds5_pkg::SIZE_W-1:0];
				hds5_pkg::REG_DIFF_GAIN:   diff_gain_q   <= cfg_wdata[hds5_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign in_ready = !clr_busy && (pend_q < CNTW'(OD));
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// results promised but not yet taken, keeps the queue from overflowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_fire && scan_ctl.emit, out_fire})
				2'b10:   pend_q <= pend_q + CNTW'(1);
				2'b01:   pend_q <= pend_q - CNTW'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	hds5_scan #(
		.GRID_MAX (GRID_MAX)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.frame_start (frame_start),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.addr        (scan_addr),
		.ctl         (scan_ctl)
	);

	hds5_window #(
		.GRID_MAX (GRID_MAX)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.addr      (scan_addr),
		.bot       (cell_value),
		.ctl       (scan_ctl),
		.clr_busy  (clr_busy),
		.ctl_s2    (ctl_s2),
		.lap_s2    (lap_s2),
		.center_s2 (center_s2)
	);

	hds5_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s2    (ctl_s2),
		.lap_s2    (lap_s2),
		.center_s2 (center_s2),
		.gain      (diff_gain_q),
		.res_valid (res_valid),
		.res       (res)
	);

	hds5_fifo #(
		.WIDTH ($bits(hds5_pkg::result_t)),
		.DEPTH (OD)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (out_fire),
		.pop_valid (out_valid),
		.pop_data  (out_res),
		.level     (out_level)
	);

	assign updated_value = $signed(out_res.value);
	assign pass_done     = out_res.last;

	// checks
	`HDS5_CHECK(a_pend_bound, pend_q <= CNTW'(OD))
	`HDS5_CHECK(a_queue_within_pend, out_level <= pend_q)
	`HDS5_IMPLY(a_no_take_while_clearing, clr_busy, !in_fire)

endmodule

### rtl/core/hds5_ram.sv
// generic single write port ram with registered read
module hds5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/hds5_scan.sv
// raster position tracking and interior cell detection
module hds5_scan #(
	parameter int GRID_MAX = hds5_pkg::GRID_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          frame_start,
	input  logic [hds5_pkg::SIZE_W-1:0]   grid_width,
	input  logic [hds5_pkg::SIZE_W-1:0]   grid_height,
	output logic [$clog2(GRID_MAX)-1:0]   addr,
	output hds5_pkg::scan_ctl_t           ctl
);

	localparam int AW = $clog2(GRID_MAX);
	localparam int SW = (AW + 1 > hds5_pkg::SIZE_W) ? AW + 1 : hds5_pkg::SIZE_W;

	logic [AW-1:0] row_q;
	logic [AW-1:0] col_q;
	logic [SW-1:0] w_use;
	logic [SW-1:0] h_use;
	logic [SW-1:0] r0, c0, r1, c1, r2;
	logic [SW-1:0] rn, cn;

	// clamp the grid size in use
	always_comb begin
		w_use = SW'(grid_width);
		if (w_use < SW'(hds5_pkg::SIZE_MIN)) begin
			w_use = SW'(hds5_pkg::SIZE_MIN);
		end else if (w_use > SW'(GRID_MAX)) begin
			w_use = SW'(GRID_MAX);
		end
		h_use = SW'(grid_height);
		if (h_use < SW'(hds5_pkg::SIZE_MIN)) begin
			h_use = SW'(hds5_pkg::SIZE_MIN);
		end else if (h_use > SW'(GRID_MAX)) begin
			h_use = SW'(GRID_MAX);
		end
	end

	// position of this cell and of the next one
	always_comb begin
		r0 = frame_start ? '0 : SW'(row_q);
		c0 = frame_start ? '0 : SW'(col_q);
		if (c0 >= w_use) begin
			c1 = '0;
			r1 = r0 + SW'(1);
		end else begin
			c1 = c0;
			r1 = r0;
		end
		r2 = (r1 >= h_use) ? '0 : r1;

		cn = c1 + SW'(1);
		rn = r2;
		if (cn >= w_use) begin
			cn = '0;
			rn = r2 + SW'(1);
			if (rn >= h_use) begin
				rn = '0;
			end
		end
	end

	assign addr     = c1[AW-1:0];
	assign ctl.emit = (r2 >= SW'(2)) && (c1 >= SW'(2));
	assign ctl.last = (r2 == h_use - SW'(1)) && (c1 == w_use - SW'(1));

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (fire) begin
			row_q <= rn[AW-1:0];
			col_q <= cn[AW-1:0];
		end
	end

endmodule

### rtl/core/hds5_window.sv
// line buffers, neighbor window and laplacian stage
module hds5_window #(
	parameter int GRID_MAX = hds5_pkg::GRID_MAX_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   fire,
	input  logic [$clog2(GRID_MAX)-1:0]            addr,
	input  logic signed [hds5_pkg::DATA_W-1:0]     bot,
	input  hds5_pkg::scan_ctl_t                    ctl,
	output logic                                   clr_busy,
	output hds5_pkg::stage_ctl_t                   ctl_s2,
	output logic signed [hds5_pkg::LAP_W-1:0]      lap_s2,
	output logic signed [hds5_pkg::DATA_W-1:0]     center_s2
);

	localparam int AW = $clog2(GRID_MAX);
	localparam int DW = hds5_pkg::DATA_W;
	localparam int LW = hds5_pkg::LAP_W;

	// clearing sweep after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// stage 1 registers
	logic                 v_s1;
	logic [AW-1:0]        addr_s1;
	logic signed [DW-1:0] bot_s1;
	hds5_pkg::scan_ctl_t  ctl_s1;
	logic                 hit_s1;
	logic signed [DW-1:0] fwd_top_s1;
	logic signed [DW-1:0] fwd_mid_s1;

	logic signed [DW-1:0] win_q [6];

	logic [DW-1:0]        upper_rdata;
	logic [DW-1:0]        middle_rdata;
	logic signed [DW-1:0] top_eff;
	logic signed [DW-1:0] mid_eff;
	logic signed [LW-1:0] lap;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [DW-1:0]        upper_wdata;
	logic [DW-1:0]        middle_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(GRID_MAX - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign clr_busy = clr_busy_q;

	// line buffer write: zero sweep, else shift the column up one row
	always_comb begin
		ram_we       = clr_busy_q | v_s1;
		ram_waddr    = clr_busy_q ? clr_addr_q : addr_s1;
		upper_wdata  = clr_busy_q ? '0 : mid_eff;
		middle_wdata = clr_busy_q ? '0 : bot_s1;
	end

	hds5_ram #(
		.WIDTH (DW),
		.DEPTH (GRID_MAX)
	) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (upper_wdata),
		.raddr (addr),
		.rdata (upper_rdata)
	);

	hds5_ram #(
		.WIDTH (DW),
		.DEPTH (GRID_MAX)
	) u_middle (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (middle_wdata),
		.raddr (addr),
		.rdata (middle_rdata)
	);

	// read data, bypassed when the column was written in the read cycle
	assign top_eff = hit_s1 ? fwd_top_s1 : $signed(upper_rdata);
	assign mid_eff = hit_s1 ? fwd_mid_s1 : $signed(middle_rdata);

	// stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			addr_s1    <= addr;
			bot_s1     <= bot;
			ctl_s1     <= ctl;
			hit_s1     <= v_s1 && (addr_s1 == addr);
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= bot_s1;
		end
	end

	// laplacian: up(0) center(1) down(2) left(4) right(mid)
	assign lap = LW'(win_q[4]) + LW'(mid_eff) + LW'(win_q[0]) + LW'(win_q[2])
		- (LW'(win_q[1]) <<< 2);

	// window shift, column c-1 moves to c-2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top_eff;
			win_q[1] <= mid_eff;
			win_q[2] <= bot_s1;
		end
	end

	// stage 2 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2.valid <= 1'b0;
			ctl_s2.last  <= 1'b0;
		end else begin
			ctl_s2.valid <= v_s1 && ctl_s1.emit;
			ctl_s2.last  <= ctl_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		lap_s2    <= lap;
		center_s2 <= win_q[1];
	end

endmodule

### rtl/core/hds5_update.sv
// gain multiply, floor shift and saturating update
module hds5_update (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hds5_pkg::stage_ctl_t                   ctl_s2,
	input  logic signed [hds5_pkg::LAP_W-1:0]      lap_s2,
	input  logic signed [hds5_pkg::DATA_W-1:0]     center_s2,
	input  logic [hds5_pkg::GAIN_W-1:0]            gain,
	output logic                                   res_valid,
	output hds5_pkg::result_t                      res
);

	localparam int DW = hds5_pkg::DATA_W;
	localparam int LW = hds5_pkg::LAP_W;
	localparam int PW = hds5_pkg::PROD_W;
	localparam int FW = hds5_pkg::FRAC_W;
	localparam int SUMW = LW + 1;

	hds5_pkg::stage_ctl_t ctl_s3;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_s3;
	logic signed [DW-1:0] center_s3;
	logic signed [LW-1:0] delta;
	logic signed [SUMW-1:0] sum;
	logic signed [DW-1:0] sat;

	// kappa times laplacian
	assign prod = PW'(lap_s2) * PW'($signed({1'b0, gain}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3.valid <= 1'b0;
			ctl_s3.last  <= 1'b0;
		end else begin
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.last  <= ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3   <= prod;
		center_s3 <= center_s2;
	end

	// floor shift by dropping the fraction, add center, saturate
	assign delta = prod_s3[FW +: LW];
	assign sum   = SUMW'(center_s3) + SUMW'(delta);

	always_comb begin
		if (sum > SUMW'(signed'({1'b0, {(DW-1){1'b1}}}))) begin
			sat = {1'b0, {(DW-1){1'b1}}};
		end else if (sum < -SUMW'(signed'({1'b0, 1'b1, {(DW-1){1'b0}}}))) begin
			sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat = sum[DW-1:0];
		end
	end

	assign res_valid = ctl_s3.valid;
	assign res.value = sat;
	assign res.last  = ctl_s3.last;

endmodule

### rtl/core/hds5_fifo.sv
// small output queue that decouples the pipeline from the consumer
module hds5_fifo #(
	parameter int WIDTH = 33,
	parameter int DEPTH = hds5_pkg::OUT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic                       pop_valid,
	output logic [WIDTH-1:0]           pop_data,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTRW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q;
	logic [PTRW-1:0]  rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign level     = count_q;

endmodule
